// File: rtl/sfpd_pkg.sv
// Shared types, constants and CRC helper for the sync-framed packet deframer.
package sfpd_pkg;

  localparam int unsigned PacketLength = 43;
  localparam int unsigned PosWidth     = 6;
  localparam int unsigned QueueDepth   = 4;

  localparam logic [PosWidth-1:0] PosFirstData = PosWidth'(2);
  localparam logic [PosWidth-1:0] PosCrcLow    = PosWidth'(PacketLength - 2);
  localparam logic [PosWidth-1:0] PosLast      = PosWidth'(PacketLength - 1);

  localparam logic [7:0]  SyncFirst  = 8'h4D;  // 'M'
  localparam logic [7:0]  SyncSecond = 8'h53;  // 'S'
  localparam logic [15:0] CrcInit    = 16'hFFFF;
  localparam logic [15:0] CrcPoly    = 16'h1021;
  localparam logic [15:0] CrcTop     = 16'h8000;
  localparam logic [15:0] LengthWord = 16'(PacketLength);

  localparam int unsigned CfgIdxWidth = 1;
  localparam logic [CfgIdxWidth-1:0] CfgExpectedVersion = 1'b0;
  localparam logic [CfgIdxWidth-1:0] CfgExpectedType    = 1'b1;

  // One packet byte handed from the front end to the back end
  typedef struct packed {
    logic [7:0]          data;
    logic [PosWidth-1:0] pos;
    logic                last;
  } item_t;

  // CRC-16/CCITT-FALSE update over one byte, MSB first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if ((c & CrcTop) != 16'h0000) begin
        c = (c << 1) ^ CrcPoly;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

  // CRC state right after the sync pair
  localparam logic [15:0] CrcAfterSync = crc_byte(crc_byte(CrcInit, SyncFirst), SyncSecond);

endpackage

// File: rtl/sfpd_front.sv
// Front end: sync hunt and byte position tracking, pushes packet bytes to the queue.
module sfpd_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         data_byte_i,
  input  logic               q_full_i,
  output logic               q_push_o,
  output sfpd_pkg::item_t    q_item_o
);

  typedef enum logic [1:0] {
    ST_HUNT,
    ST_SYNC1,
    ST_COLLECT
  } state_e;

  state_e                          state_q;
  logic [sfpd_pkg::PosWidth-1:0]   pos_q;
  logic                            accept;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  // Only bytes inside a packet go to the back end
  assign q_push_o       = accept && (state_q == ST_COLLECT);
  assign q_item_o.data  = data_byte_i;
  assign q_item_o.pos   = pos_q;
  assign q_item_o.last  = (pos_q == sfpd_pkg::PosLast);

  // Hunt for 'M','S', then count out the packet
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_HUNT;
      pos_q   <= '0;
    end else if (accept) begin
      unique case (state_q)
        ST_HUNT: begin
          if (data_byte_i == sfpd_pkg::SyncFirst) begin
            state_q <= ST_SYNC1;
          end
        end
        ST_SYNC1: begin
          if (data_byte_i == sfpd_pkg::SyncSecond) begin
            state_q <= ST_COLLECT;
            pos_q   <= sfpd_pkg::PosFirstData;
          end else if (data_byte_i != sfpd_pkg::SyncFirst) begin
            state_q <= ST_HUNT;
          end
        end
        ST_COLLECT: begin
          if (pos_q == sfpd_pkg::PosLast) begin
            state_q <= ST_HUNT;
            pos_q   <= '0;
          end else begin
            pos_q <= pos_q + 1'b1;
          end
        end
        default: begin
          state_q <= ST_HUNT;
        end
      endcase
    end
  end

endmodule

// File: rtl/sfpd_fifo.sv
// Short register queue that decouples the front end from the back end.
module sfpd_fifo #(
  parameter int unsigned Depth = sfpd_pkg::QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  sfpd_pkg::item_t  item_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output sfpd_pkg::item_t  item_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrMax = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  sfpd_pkg::item_t  mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntFull);
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrMax) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrMax) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// File: rtl/sfpd_back.sv
// Back end: CRC, byte capture, packet checks, counters and the result register.
module sfpd_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  sfpd_pkg::item_t     q_item_i,
  output logic                q_pop_o,
  input  logic [7:0]          expected_version_i,
  input  logic [7:0]          expected_type_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                packet_ok_o,
  output logic [31:0]         sequence_res_o,
  output logic [15:0]         sample_rate_o,
  output logic [31:0]         date_packed_o,
  output logic [39:0]         time_packed_o,
  output logic [63:0]         stream_id_o,
  output logic [3:0]          stream_id_length_o,
  output logic signed [31:0]  x_value_o,
  output logic signed [31:0]  y_value_o,
  output logic signed [31:0]  z_value_o,
  output logic [31:0]         good_count_o,
  output logic [31:0]         bad_count_o
);

  localparam int unsigned LastStored = sfpd_pkg::PacketLength - 2;

  logic [7:0]   pkt_q [2:LastStored];
  logic [15:0]  crc_q, crc_src;
  logic [31:0]  good_q, good_d, bad_q, bad_d;
  logic         out_valid_q;
  logic         slot_free, do_pop, finish, ok;
  logic [63:0]  sid;

  // Identifier length: bytes before the first zero, at most eight
  function automatic logic [3:0] sid_len(input logic [63:0] s);
    logic [3:0] n;
    logic       ended;
    n     = '0;
    ended = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (s[8*i +: 8] == 8'h00) begin
        ended = 1'b1;
      end
      if (!ended) begin
        n = n + 1'b1;
      end
    end
    return n;
  endfunction

  assign slot_free = !out_valid_q || out_ready_i;
  // A last byte waits until the result register can take the packet
  assign do_pop    = q_valid_i && (!q_item_i.last || slot_free);
  assign q_pop_o   = do_pop;
  assign finish    = do_pop && q_item_i.last;

  // CRC restarts from the post-sync value at the first payload byte
  assign crc_src = (q_item_i.pos == sfpd_pkg::PosFirstData) ? sfpd_pkg::CrcAfterSync : crc_q;

  assign sid = {pkt_q[28], pkt_q[27], pkt_q[26], pkt_q[25],
                pkt_q[24], pkt_q[23], pkt_q[22], pkt_q[21]};

  // Header, length and CRC check on the final byte
  assign ok = (pkt_q[2] == expected_version_i)
           && (pkt_q[3] == expected_type_i)
           && ({pkt_q[5], pkt_q[4]} == sfpd_pkg::LengthWord)
           && ({q_item_i.data, pkt_q[LastStored]} == crc_q);

  // Saturating packet counters
  always_comb begin
    good_d = good_q;
    bad_d  = bad_q;
    if (ok) begin
      if (good_q != 32'hFFFF_FFFF) begin
        good_d = good_q + 32'd1;
      end
    end else if (bad_q != 32'hFFFF_FFFF) begin
      bad_d = bad_q + 32'd1;
    end
  end

  // Byte capture (stored bytes are read at fixed places only)
  always_ff @(posedge clk_i) begin
    if (do_pop && !q_item_i.last) begin
      pkt_q[q_item_i.pos] <= q_item_i.data;
    end
  end

  // Running CRC over bytes 2..40
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= sfpd_pkg::CrcInit;
    end else if (do_pop && (q_item_i.pos < sfpd_pkg::PosCrcLow)) begin
      crc_q <= sfpd_pkg::crc_byte(crc_src, q_item_i.data);
    end
  end

  // Counters and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      good_q      <= '0;
      bad_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (finish) begin
        good_q      <= good_d;
        bad_q       <= bad_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (finish) begin
      packet_ok_o        <= ok;
      sequence_res_o     <= {pkt_q[9], pkt_q[8], pkt_q[7], pkt_q[6]};
      sample_rate_o      <= {pkt_q[11], pkt_q[10]};
      date_packed_o      <= {pkt_q[13], pkt_q[12], pkt_q[14], pkt_q[15]};
      time_packed_o      <= {pkt_q[16], pkt_q[17], pkt_q[18], pkt_q[20], pkt_q[19]};
      stream_id_o        <= sid;
      stream_id_length_o <= sid_len(sid);
      x_value_o          <= {pkt_q[32], pkt_q[31], pkt_q[30], pkt_q[29]};
      y_value_o          <= {pkt_q[36], pkt_q[35], pkt_q[34], pkt_q[33]};
      z_value_o          <= {pkt_q[40], pkt_q[39], pkt_q[38], pkt_q[37]};
      good_count_o       <= good_d;
      bad_count_o        <= bad_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: rtl/sync_framed_packet_deframer_crc16.sv
// Top level of the sync-framed packet deframer with CRC-16 check.
// Throughput: one byte per cycle; the byte queue absorbs short output stalls.
// The final packet byte passes through the byte queue, then the back end loads the result
// register and raises out_valid_o.
// A stalled result holds the next packet's last byte at the head of the byte queue; input stalls
// only once the byte queue fills. Hunt bytes are never queued.
// Reset (async, active low) returns to sync hunt, clears counters and the queue.
module sync_framed_packet_deframer_crc16 #(
  parameter int unsigned QueueDepth = sfpd_pkg::QueueDepth
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [7:0]                           data_byte_i,
  input  logic                                 cfg_we_i,
  input  logic [sfpd_pkg::CfgIdxWidth-1:0]     cfg_idx_i,
  input  logic [7:0]                           cfg_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic                                 packet_ok_o,
  output logic [31:0]                          sequence_res_o,
  output logic [15:0]                          sample_rate_o,
  output logic [31:0]                          date_packed_o,
  output logic [39:0]                          time_packed_o,
  output logic [63:0]                          stream_id_o,
  output logic [3:0]                           stream_id_length_o,
  output logic signed [31:0]                   x_value_o,
  output logic signed [31:0]                   y_value_o,
  output logic signed [31:0]                   z_value_o,
  output logic [31:0]                          good_count_o,
  output logic [31:0]                          bad_count_o
);

  logic             q_full, q_push, q_valid, q_pop;
  sfpd_pkg::item_t  q_in, q_out;
  logic [7:0]       exp_version_q, exp_type_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_version_q <= 8'd1;
      exp_type_q    <= 8'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        sfpd_pkg::CfgExpectedVersion: exp_version_q <= cfg_data_i;
        sfpd_pkg::CfgExpectedType:    exp_type_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  sfpd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .data_byte_i (data_byte_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_item_o    (q_in)
  );

  sfpd_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (q_out)
  );

  sfpd_back u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .q_valid_i          (q_valid),
    .q_item_i           (q_out),
    .q_pop_o            (q_pop),
    .expected_version_i (exp_version_q),
    .expected_type_i    (exp_type_q),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .packet_ok_o        (packet_ok_o),
    .sequence_res_o     (sequence_res_o),
    .sample_rate_o      (sample_rate_o),
    .date_packed_o      (date_packed_o),
    .time_packed_o      (time_packed_o),
    .stream_id_o        (stream_id_o),
    .stream_id_length_o (stream_id_length_o),
    .x_value_o          (x_value_o),
    .y_value_o          (y_value_o),
    .z_value_o          (z_value_o),
    .good_count_o       (good_count_o),
    .bad_count_o        (bad_count_o)
  );

endmodule

// File: rtl/sfpd_checker.sv
// Port-level checker for the deframer, bound to the top level.
module sfpd_checker (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         out_valid_i,
  input  logic         out_ready_i,
  input  logic         packet_ok_i,
  input  logic [63:0]  stream_id_i,
  input  logic [3:0]   stream_id_length_i,
  input  logic [31:0]  good_count_i,
  input  logic [31:0]  bad_count_i
);

  // A held result keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(good_count_i)
      && $stable(bad_count_i) && $stable(packet_ok_i))
    else $error("result changed while stalled");

  // A good packet has been counted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && packet_ok_i |-> good_count_i != 32'd0)
    else $error("good packet with zero good count");

  // A rejected packet has been counted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !packet_ok_i |-> bad_count_i != 32'd0)
    else $error("bad packet with zero bad count");

  // Identifier length agrees with its first byte and never exceeds eight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> stream_id_length_i <= 4'd8
      && ((stream_id_i[7:0] == 8'h00) == (stream_id_length_i == 4'd0)))
    else $error("identifier length inconsistent");

endmodule

bind sync_framed_packet_deframer_crc16 sfpd_checker u_sfpd_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .out_valid_i        (out_valid_o),
  .out_ready_i        (out_ready_i),
  .packet_ok_i        (packet_ok_o),
  .stream_id_i        (stream_id_o),
  .stream_id_length_i (stream_id_length_o),
  .good_count_i       (good_count_o),
  .bad_count_i        (bad_count_o)
);
